// ===== design/frc_pkg.sv =====
`timescale 1ns / 1ps
package frc_pkg;

   localparam logic [7:0] CHAR_HEADER  = 8'h3E;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;

   localparam int unsigned CSR_ADDR_BITS = 3;
   localparam int unsigned REQ_DATA_BITS = 8;
   localparam int unsigned RSP_DATA_BITS = 112;

   localparam logic [15:0] MIN_LEN_RESET     = 16'd31;
   localparam logic [31:0] BASE_OFFSET_RESET = 32'd0;

   typedef enum logic {
      REG_MIN_LEN     = 1'b0,
      REG_BASE_OFFSET = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [15:0] min_len;
      logic [31:0] base_offset;
   } cfg_type;

   // tdata layout, lowest bits last in this list
   typedef struct packed {
      logic [2:0]  pad;
      logic        empty_error;
      logic [31:0] block_end;
      logic [31:0] record_count;
      logic [1:0]  dropped_count;
      logic        sequence_start;
      logic        header_start;
      logic [7:0]  write_byte;
      logic [31:0] write_addr;
   } rsp_word_type;

   typedef struct packed {
      logic         done_res;
      rsp_word_type word;
   } result_type;

endpackage

// ===== design/frc_csr.sv =====
`timescale 1ns / 1ps
module frc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [frc_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready,
   output frc_pkg::cfg_type                     cfg
);
   import frc_pkg::*;

   logic [15:0]   min_len_ff;
   logic [31:0]   base_offset_ff;
   logic          wr_en;
   csr_index_type sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign sel        = csr_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff     <= MIN_LEN_RESET;
         base_offset_ff <= BASE_OFFSET_RESET;
      end else if (wr_en) begin
         unique case (sel)
            REG_MIN_LEN:     min_len_ff     <= csr_pwdata[15:0];
            REG_BASE_OFFSET: base_offset_ff <= csr_pwdata;
            default:         ;
         endcase
      end
   end

   always_comb begin
      unique case (sel)
         REG_MIN_LEN:     csr_prdata = {16'd0, min_len_ff};
         REG_BASE_OFFSET: csr_prdata = base_offset_ff;
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign cfg.min_len     = min_len_ff;
   assign cfg.base_offset = base_offset_ff;

endmodule

// ===== design/frc_core.sv =====
`timescale 1ns / 1ps
module frc_core #(
   parameter int unsigned ADDR_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic [7:0]          text_byte,
   input  logic                last,
   input  frc_pkg::cfg_type    cfg,
   output frc_pkg::result_type result
);
   import frc_pkg::*;

   localparam logic [15:0] LEN_MAX = '1;

   logic [ADDR_BITS-1:0] byte_position_ff, byte_position_in;
   logic [ADDR_BITS-1:0] removed_total_ff, removed_total_in;
   logic                 in_header_ff, in_header_in;
   logic                 in_sequence_ff, in_sequence_in;
   logic [15:0]          sequence_length_ff, sequence_length_in;
   logic                 pending_newline_ff, pending_newline_in;
   logic [ADDR_BITS-1:0] header_pos_ff, header_pos_in;
   logic [ADDR_BITS-1:0] sequence_pos_ff, sequence_pos_in;
   logic [31:0]          kept_records_ff, kept_records_in;
   logic                 block_open_ff, block_open_in;

   logic [ADDR_BITS-1:0] bp_base;
   logic [ADDR_BITS-1:0] rm_v;
   logic [ADDR_BITS-1:0] idx;
   logic [ADDR_BITS-1:0] end_v;
   logic [15:0]          len_v;
   logic [31:0]          kept_v;
   logic [ADDR_BITS-1:0] hdr_v;
   logic [ADDR_BITS-1:0] seq_v;
   logic                 hdr_flag;
   logic                 seq_flag;
   logic                 pend_v;
   logic [1:0]           drops;
   logic                 hs;
   logic                 ss;

   always_comb begin
      bp_base = block_open_ff ? byte_position_ff : ADDR_BITS'(cfg.base_offset);
      rm_v     = removed_total_ff;
      len_v    = sequence_length_ff;
      kept_v   = kept_records_ff;
      hdr_v    = header_pos_ff;
      seq_v    = sequence_pos_ff;
      hdr_flag = in_header_ff;
      seq_flag = in_sequence_ff;
      pend_v   = 1'b0;
      drops    = 2'd0;
      hs       = 1'b0;
      ss       = 1'b0;
      end_v    = '0;

      // line break before this byte: removed, or ends a record
      if (pending_newline_ff) begin
         if (text_byte != CHAR_HEADER) begin
            rm_v = rm_v + ADDR_BITS'(1);
         end else if (len_v < cfg.min_len) begin
            if (len_v != LEN_MAX) len_v = len_v + 16'd1;
            rm_v = rm_v + ADDR_BITS'(len_v) + (seq_v - hdr_v) + ADDR_BITS'(1);
            if (kept_v != 32'd0) kept_v = kept_v - 32'd1;
            drops = drops + 2'd1;
         end
      end

      idx = bp_base - rm_v;

      case (text_byte)
         CHAR_HEADER: begin
            hdr_v    = idx;
            len_v    = 16'd0;
            hdr_flag = 1'b1;
            seq_flag = 1'b0;
            kept_v   = kept_v + 32'd1;
            hs       = 1'b1;
         end
         CHAR_NEWLINE: begin
            if (hdr_flag && !last) begin
               seq_v    = idx + ADDR_BITS'(1);
               hdr_flag = 1'b0;
               seq_flag = 1'b1;
               ss       = 1'b1;
            end else if (seq_flag && !last) begin
               pend_v = 1'b1;
            end
         end
         CHAR_STAR: begin
            if (seq_flag) rm_v = rm_v + ADDR_BITS'(1);
         end
         default: begin
            if (seq_flag && len_v != LEN_MAX) len_v = len_v + 16'd1;
         end
      endcase

      if (last) begin
         if (len_v < cfg.min_len) begin
            if (seq_flag) begin
               rm_v = rm_v + ADDR_BITS'(len_v) + (seq_v - hdr_v) + ADDR_BITS'(1);
               if (kept_v != 32'd0) kept_v = kept_v - 32'd1;
               drops = drops + 2'd1;
            end else if (hdr_flag) begin
               rm_v = rm_v + (idx - hdr_v) + ADDR_BITS'(2);
               if (kept_v != 32'd0) kept_v = kept_v - 32'd1;
               drops = drops + 2'd1;
            end
         end
         end_v = bp_base - rm_v;
      end
   end

   always_comb begin
      if (last) begin
         byte_position_in   = ADDR_BITS'(cfg.base_offset);
         removed_total_in   = '0;
         in_header_in       = 1'b0;
         in_sequence_in     = 1'b0;
         sequence_length_in = 16'd0;
         pending_newline_in = 1'b0;
         header_pos_in      = '0;
         sequence_pos_in    = '0;
         kept_records_in    = 32'd0;
         block_open_in      = 1'b0;
      end else begin
         byte_position_in   = bp_base + ADDR_BITS'(1);
         removed_total_in   = rm_v;
         in_header_in       = hdr_flag;
         in_sequence_in     = seq_flag;
         sequence_length_in = len_v;
         pending_newline_in = pend_v;
         header_pos_in      = hdr_v;
         sequence_pos_in    = seq_v;
         kept_records_in    = kept_v;
         block_open_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff   <= '0;
         removed_total_ff   <= '0;
         in_header_ff       <= 1'b0;
         in_sequence_ff     <= 1'b0;
         sequence_length_ff <= 16'd0;
         pending_newline_ff <= 1'b0;
         header_pos_ff      <= '0;
         sequence_pos_ff    <= '0;
         kept_records_ff    <= 32'd0;
         block_open_ff      <= 1'b0;
      end else if (fire) begin
         byte_position_ff   <= byte_position_in;
         removed_total_ff   <= removed_total_in;
         in_header_ff       <= in_header_in;
         in_sequence_ff     <= in_sequence_in;
         sequence_length_ff <= sequence_length_in;
         pending_newline_ff <= pending_newline_in;
         header_pos_ff      <= header_pos_in;
         sequence_pos_ff    <= sequence_pos_in;
         kept_records_ff    <= kept_records_in;
         block_open_ff      <= block_open_in;
      end
   end

   always_comb begin
      result.done_res              = last;
      result.word.pad              = 3'd0;
      result.word.empty_error      = last && (kept_v == 32'd0);
      result.word.block_end        = 32'(end_v);
      result.word.record_count     = kept_v;
      result.word.dropped_count    = drops;
      result.word.sequence_start   = ss;
      result.word.header_start     = hs;
      result.word.write_byte       = text_byte;
      result.word.write_addr       = 32'(idx);
   end

`ifndef SYNTHESIS
   a_one_region: assert property (@(posedge clock) disable iff (reset)
      !(in_header_ff && in_sequence_ff))
      else $error("header and sequence flags both set");

   a_pend_in_seq: assert property (@(posedge clock) disable iff (reset)
      pending_newline_ff |-> in_sequence_ff)
      else $error("line break pending outside a sequence");

   a_block_close: assert property (@(posedge clock) disable iff (reset)
      fire && last |=> !block_open_ff && removed_total_ff == '0 && kept_records_ff == 32'd0)
      else $error("state not cleared after final word");
`endif

endmodule

// ===== design/frc_out_buf.sv =====
`timescale 1ns / 1ps
module frc_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  frc_pkg::result_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output frc_pkg::result_type out_data
);
   import frc_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       in_fire;
   logic       out_fire;

   assign in_ready = !skid_valid_ff;
   assign in_fire  = in_valid && in_ready;
   assign out_fire = out_valid_ff && out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (out_fire) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_fire;
            out_data_in  = in_data;
         end
      end else if (in_fire) begin
         if (!out_valid_ff) begin
            out_valid_in = 1'b1;
            out_data_in  = in_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// ===== design/fasta_record_compactor.sv =====
`timescale 1ns / 1ps
// fasta_record_compactor: compacts a FASTA text block in place, one byte a cycle while req_tready is high.
// req channel: one text byte per word in req_tdata, req_tlast on the final byte
// of the block. rsp channel: one result word per accepted byte, giving the
// compacted write address, the byte, header and sequence start flags, records
// dropped in this step, the kept record count and, on the word with rsp_tlast,
// the compacted end of block and the empty flag.
// csr port: min_len at address 0, base offset at address 4; write only while
// the block is idle. the base offset is sampled on the first byte of each block.
// the result word of each accepted byte is registered in the output buffer before it reaches rsp.
// throughput: one byte per cycle while req_tready is high, set by the state update loop.
// a two-word output buffer keeps req_tready high after the receiver stalls until
// the skid word fills; req_tready drops only while both buffer words are full.
// reset clears the parse state, empties the output buffer and restores
// min_len to 31 and the base offset to 0.
module fasta_record_compactor #(
   parameter int unsigned ADDR_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [frc_pkg::REQ_DATA_BITS-1:0]    req_tdata,  // text_byte
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // write_addr, write_byte, header_start, sequence_start, dropped_count,
   // record_count, block_end, empty_error, zero pad
   output logic [frc_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [frc_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import frc_pkg::*;

   cfg_type    cfg;
   result_type core_result;
   result_type buf_result;
   logic       req_fire;

   assign req_fire = req_tvalid && req_tready;

   frc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   frc_core #(
      .ADDR_BITS (ADDR_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (req_fire),
      .text_byte (req_tdata),
      .last      (req_tlast),
      .cfg       (cfg),
      .result    (core_result)
   );

   frc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (core_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (buf_result)
   );

   assign rsp_tdata = buf_result.word;
   assign rsp_tlast = buf_result.done_res;

endmodule
